[sv/tcp_flow_table_tracker_core_assert.svh]
// ----------------------------------------------------------------------------
// TCP flow table tracker assertion macros
// Shared concurrent assertion forms for the flow tracker checkers.
// ----------------------------------------------------------------------------
`ifndef TCP_FLOW_TABLE_TRACKER_CORE_ASSERT_SVH
`define TCP_FLOW_TABLE_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TFT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flow tracker check failed");

// next-cycle implication, disabled during reset
`define TFT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow tracker check failed");

`endif

[sv/tft_pkg.sv]
// ----------------------------------------------------------------------------
// TCP flow table tracker package
// Types, codes and constants shared by the flow tracker modules.
// ----------------------------------------------------------------------------
package tft_pkg;

   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 3;

   localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   // header lengths count 32-bit words: bytes = words << 2
   localparam int          HDR_WORD_SHIFT = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [2:0] tft_status_type;
   localparam tft_status_type ST_SHORT    = 3'd0;
   localparam tft_status_type ST_NOT_TCP  = 3'd1;
   localparam tft_status_type ST_EMPTY    = 3'd2;
   localparam tft_status_type ST_APPENDED = 3'd3;
   localparam tft_status_type ST_NEW      = 3'd4;
   localparam tft_status_type ST_FULL     = 3'd5;

   typedef enum logic [1:0] {
      KIND_SHORT,
      KIND_NOT_TCP,
      KIND_EMPTY,
      KIND_LOOKUP
   } tft_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CALC,
      S_FINISH
   } tft_state_type;

   // fields listed from the top bit down so the struct overlays the bus word
   typedef struct packed {
      logic [31:0] ack_number;
      logic [31:0] sequence_number;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [31:0] source_address;
      logic [3:0]  tcp_header_words;
      logic [15:0] ip_total_length;
      logic [3:0]  ip_header_words;
      logic [7:0]  ip_protocol;
      logic [15:0] frame_length;
   } tft_req_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
   } tft_tuple_type;

   typedef struct packed {
      tft_kind_type  kind;
      logic [15:0]   plen;
      tft_tuple_type tuple;
      logic [31:0]   seq;
      logic [31:0]   ack;
   } tft_item_type;

   typedef struct packed {
      tft_tuple_type tuple;
      logic [31:0]   base_seq;
      logic [31:0]   base_ack;
      logic [31:0]   byte_count;
   } tft_entry_type;

   typedef struct packed {
      tft_status_type status;
      logic [5:0]     flow_index;
      logic [31:0]    payload_offset;
      logic [15:0]    payload_length;
      logic [31:0]    flow_bytes;
   } tft_result_type;

endpackage

[sv/tft_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tft_front.sv]
// ----------------------------------------------------------------------------
// Flow tracker front end
// Classifies one header word and works out the TCP payload length.
// ----------------------------------------------------------------------------
module tft_front (
   input  tft_pkg::tft_req_type  req,
   output tft_pkg::tft_item_type item
);
   import tft_pkg::*;

   logic [6:0]  headers;
   logic [15:0] headers_ext;
   logic        is_short;
   logic        is_not_tcp;
   logic        is_empty;

   always_comb begin
      headers = 7'({2'b00, req.ip_header_words} << HDR_WORD_SHIFT)
              + 7'({2'b00, req.tcp_header_words} << HDR_WORD_SHIFT);
      headers_ext = {9'd0, headers};
      is_short    = req.frame_length <= ETH_HDR_BYTES;
      is_not_tcp  = req.ip_protocol != PROTO_TCP;
      is_empty    = req.ip_total_length <= headers_ext;

      item.tuple.src_addr = req.source_address;
      item.tuple.dst_addr = req.dest_address;
      item.tuple.sport    = req.source_port;
      item.tuple.dport    = req.dest_port;
      item.seq            = req.sequence_number;
      item.ack            = req.ack_number;
      item.plen           = 16'd0;

      priority if (is_short) begin
         item.kind = KIND_SHORT;
      end else if (is_not_tcp) begin
         item.kind = KIND_NOT_TCP;
      end else if (is_empty) begin
         item.kind = KIND_EMPTY;
      end else begin
         item.kind = KIND_LOOKUP;
         item.plen = req.ip_total_length - headers_ext;
      end
   end

endmodule

[sv/tft_queue.sv]
// ----------------------------------------------------------------------------
// Flow tracker item queue
// Short FIFO that decouples header intake from the table lookup.
// ----------------------------------------------------------------------------
module tft_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tft_pkg::tft_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tft_pkg::tft_item_type out_item
);
   import tft_pkg::*;

   tft_item_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = fill_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[sv/tft_back.sv]
// ----------------------------------------------------------------------------
// Flow tracker back end
// Scans the flow table, updates or inserts the flow and forms the result.
// ----------------------------------------------------------------------------
module tft_back #(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  tft_pkg::tft_item_type   item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tft_pkg::tft_result_type rsp
);
   import tft_pkg::*;

   localparam int IDX_W   = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(FLOW_ENTRIES + 1);
   localparam int ENTRY_W = $bits(tft_entry_type);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(FLOW_ENTRIES);

   tft_state_type    state_ff, state_in;
   tft_item_type     item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   tft_entry_type    hit_entry_ff, hit_entry_in;
   logic [31:0]      d_seq_ff, d_seq_in;
   logic [31:0]      d_ack_ff, d_ack_in;
   logic [31:0]      bytes_ff, bytes_in;
   logic             rsp_vld_ff, rsp_vld_in;
   tft_result_type   rsp_ff, rsp_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   tft_entry_type      wr_entry;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   tft_entry_type      entry_rd;

   logic        scan_more;
   logic        found;
   logic        out_free;
   logic        room;
   logic [32:0] bytes_sum;

   function automatic logic tuple_match(tft_tuple_type e, tft_tuple_type p);
      logic fwd;
      logic rev;
      fwd = e.src_addr == p.src_addr && e.dst_addr == p.dst_addr &&
            e.sport == p.sport && e.dport == p.dport;
      rev = e.src_addr == p.dst_addr && e.dst_addr == p.src_addr &&
            e.sport == p.dport && e.dport == p.sport;
      return fwd || rev;
   endfunction

   tft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FLOW_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry_rd   = tft_entry_type'(rd_data);
   assign rd_addr    = issue_ff[IDX_W-1:0];
   assign scan_more  = issue_ff < count_ff;
   assign found      = cmp_vld_ff && tuple_match(entry_rd.tuple, item_ff.tuple);
   assign out_free   = !rsp_vld_ff || rsp_ready;
   assign room       = count_ff < COUNT_MAX;
   assign bytes_sum  = {1'b0, hit_entry_ff.byte_count} + {17'd0, item_ff.plen};
   assign item_ready = state_ff == S_IDLE;
   assign rsp_valid  = rsp_vld_ff;
   assign rsp        = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               state_in = (item.kind == KIND_LOOKUP) ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (found) begin
               state_in = S_CALC;
            end else if (!scan_more && !cmp_vld_ff) begin
               state_in = S_FINISH;
            end
         end
         S_CALC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in      = item_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      d_seq_in     = d_seq_ff;
      d_ack_in     = d_ack_ff;
      bytes_in     = bytes_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_entry     = hit_entry_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               issue_in = '0;
               hit_in   = 1'b0;
            end
         end
         S_SCAN: begin
            if (found) begin
               hit_in       = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_entry_in = entry_rd;
            end else if (scan_more) begin
               // read one entry a cycle, compare it the cycle after
               issue_in   = issue_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
            end
         end
         S_CALC: begin
            d_seq_in = item_ff.seq - hit_entry_ff.base_seq;
            d_ack_in = item_ff.ack - hit_entry_ff.base_ack;
            bytes_in = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = '0;
               unique case (item_ff.kind)
                  KIND_SHORT:   rsp_in.status = ST_SHORT;
                  KIND_NOT_TCP: rsp_in.status = ST_NOT_TCP;
                  KIND_EMPTY:   rsp_in.status = ST_EMPTY;
                  KIND_LOOKUP: begin
                     rsp_in.payload_length = item_ff.plen;
                     priority if (hit_ff) begin
                        rsp_in.status         = ST_APPENDED;
                        rsp_in.flow_index     = 6'(hit_idx_ff);
                        rsp_in.payload_offset = d_seq_ff + d_ack_ff;
                        rsp_in.flow_bytes     = bytes_ff;
                        wr_en                 = 1'b1;
                        wr_addr               = hit_idx_ff;
                        wr_entry              = hit_entry_ff;
                        wr_entry.byte_count   = bytes_ff;
                     end else if (room) begin
                        rsp_in.status       = ST_NEW;
                        rsp_in.flow_index   = 6'(count_ff[IDX_W-1:0]);
                        rsp_in.flow_bytes   = {16'd0, item_ff.plen};
                        wr_en               = 1'b1;
                        wr_addr             = count_ff[IDX_W-1:0];
                        wr_entry.tuple      = item_ff.tuple;
                        wr_entry.base_seq   = item_ff.seq;
                        wr_entry.base_ack   = item_ff.ack;
                        wr_entry.byte_count = {16'd0, item_ff.plen};
                        count_in            = count_ff + CNT_W'(1);
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         issue_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         hit_ff     <= hit_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      d_seq_ff     <= d_seq_in;
      d_ack_ff     <= d_ack_in;
      bytes_ff     <= bytes_in;
      rsp_ff       <= rsp_in;
   end

endmodule

[sv/tcp_flow_table_tracker_core.sv]
// ----------------------------------------------------------------------------
// TCP flow table tracker core
// Classifies parsed TCP/IPv4 headers and tracks flows in a searched table.
// ----------------------------------------------------------------------------
// Each request word carries the parsed header fields of one frame; each
// produces exactly one response word, in order. Short frames, non-TCP
// packets and empty payloads pass the table by and go from idle straight to
// the finish state. A packet with payload scans the flow table one entry per
// cycle through the single read port of the table RAM, up to the first hit
// or the last entry below the flow count; a hit then passes through the calc
// state to work out the offset and byte count before the finish state.
// A four-word queue between the header classifier and the table sequencer
// takes up to four request words while a lookup is running or a response
// waits on rsp_tready. The table needs no clearing after reset: only
// entries below the flow count are searched.
module tcp_flow_table_tracker_core #(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_length, ip_protocol, ip_header_words, ip_total_length,
   // tcp_header_words, source_address, dest_address, source_port,
   // dest_port, sequence_number, ack_number
   input  logic [tft_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // flow_index, payload_offset, payload_length, flow_bytes, zero pad
   output logic [tft_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [tft_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import tft_pkg::*;

   tft_req_type    req;
   tft_item_type   front_item;
   tft_item_type   queue_item;
   logic           queue_valid;
   logic           queue_ready;
   tft_result_type result;

   assign req = tft_req_type'(req_tdata);

   tft_front u_front (
      .req  (req),
      .item (front_item)
   );

   tft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   tft_back #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (result)
   );

   assign rsp_tdata = {2'b00, result.flow_bytes, result.payload_length,
                       result.payload_offset, result.flow_index};
   assign rsp_tuser = result.status;

endmodule

[sv/tft_checker.sv]
// ----------------------------------------------------------------------------
// TCP flow table tracker checker
// Port-level checks on the response stream of the flow tracker core.
// ----------------------------------------------------------------------------
`include "tcp_flow_table_tracker_core_assert.svh"

module tft_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [tft_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tft_pkg::*;

   logic [5:0]  flow_index;
   logic [31:0] payload_offset;
   logic [15:0] payload_length;
   logic [31:0] flow_bytes;
   logic        bypassed;

   assign flow_index     = rsp_tdata[5:0];
   assign payload_offset = rsp_tdata[37:6];
   assign payload_length = rsp_tdata[53:38];
   assign flow_bytes     = rsp_tdata[85:54];
   assign bypassed       = rsp_tuser == ST_SHORT || rsp_tuser == ST_NOT_TCP ||
                           rsp_tuser == ST_EMPTY;

   // packets that skip the table carry nothing but their status
   `TFT_ASSERT_IMP(a_bypass_zero, clock, reset, rsp_tvalid && bypassed, rsp_tdata == '0)

   // a full table reports the length only
   `TFT_ASSERT_IMP(a_full_fields, clock, reset, rsp_tvalid && rsp_tuser == ST_FULL,
      flow_index == 6'd0 && payload_offset == 32'd0 && flow_bytes == 32'd0 &&
      payload_length != 16'd0)

   // a new flow starts its count at this packet's length
   `TFT_ASSERT_IMP(a_new_flow, clock, reset, rsp_tvalid && rsp_tuser == ST_NEW,
      payload_offset == 32'd0 && flow_bytes == {16'd0, payload_length} &&
      payload_length != 16'd0)

   // an appended packet grows the count by at least its own length
   `TFT_ASSERT_IMP(a_append_bytes, clock, reset, rsp_tvalid && rsp_tuser == ST_APPENDED,
      payload_length != 16'd0 && flow_bytes >= {16'd0, payload_length})

   // hold a stalled response word
   `TFT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind tcp_flow_table_tracker_core tft_checker u_tft_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
